// ===== hw/rtl/ced_pkg.sv =====
// shared types, character codes and helpers for the escape sequence decoder
`timescale 1ns / 1ps

package ced_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_HEX0,
    MODE_HEX1,
    MODE_STOPPED
  } mode_t;

  localparam int unsigned COUNT_W = 15;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic REG_STOP = 1'b0;
  localparam logic REG_KEPT = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef struct packed {
    logic               kind;
    logic [7:0]         ch;
    logic [COUNT_W-1:0] count;
    logic               last;
  } result_t;

  // up to two results written into the result queue per accepted byte
  typedef struct packed {
    logic [1:0] n;
    result_t    a;
    result_t    b;
  } push_t;

  typedef struct packed {
    mode_t              mode;
    logic [COUNT_W-1:0] count;
  } status_t;

  function automatic result_t mk_char(input logic [7:0] ch);
    result_t r;
    r.kind  = KIND_CHAR;
    r.ch    = ch;
    r.count = '0;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_done(input logic [COUNT_W-1:0] cnt);
    result_t r;
    r.kind  = KIND_DONE;
    r.ch    = CH_NUL;
    r.count = cnt;
    r.last  = 1'b0;
    return r;
  endfunction

  // {valid, value} of a hex digit character
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/c_escape_sequence_decoder.sv =====
// top level of the C escape sequence decoder
`timescale 1ns / 1ps

//  channel  handshake            payload
//  in       in_valid / in_ready  in_byte
//  out      out_valid/out_ready  out_kind, out_byte, consumed_count, last_of_run
//  cfg      cfg_write            cfg_index, cfg_data
//
//  one byte per cycle is decoded in a single pass into a four-entry result queue while in_ready is high
//  a byte yields zero, one or two results; the queue drains one result per cycle while out_ready is high
//  so bytes that give two results limit the input rate
//  in_ready stays high while the queue has room for two results
//  reset clears the decode state, the queue and both registers

module c_escape_sequence_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic [14:0] consumed_count,
  output logic        last_of_run,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic               stop_at_quote_or_ctrl;
  logic [7:0]         kept_control_byte;
  logic               accept;
  ced_pkg::push_t     push;
  ced_pkg::status_t   status;
  ced_pkg::result_t   head;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_at_quote_or_ctrl <= 1'b0;
      kept_control_byte     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ced_pkg::REG_STOP: stop_at_quote_or_ctrl <= cfg_data[0];
        ced_pkg::REG_KEPT: kept_control_byte     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  ced_step u_step (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .stop    (stop_at_quote_or_ctrl),
    .kept    (kept_control_byte),
    .push    (push),
    .status  (status)
  );

  ced_rq u_rq (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (accept),
    .push       (push),
    .space_ok   (in_ready),
    .head_valid (out_valid),
    .head_ready (out_ready),
    .head       (head)
  );

  assign out_kind       = head.kind;
  assign out_byte       = head.ch;
  assign consumed_count = head.count;
  assign last_of_run    = head.last;

  // a done result always closes the run of its byte
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == ced_pkg::KIND_DONE |-> last_of_run)
    else $error("done result without last_of_run");

  // decoded zero bytes are never delivered
  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == ced_pkg::KIND_CHAR |-> out_byte != ced_pkg::CH_NUL &&
    consumed_count == '0)
    else $error("bad character result");

  // a terminator in any mode returns the decoder to its reset state
  a_term_resets: assert property (@(posedge clk) disable iff (rst)
    accept && in_byte == ced_pkg::CH_NUL |=>
    status.mode == ced_pkg::MODE_NORMAL && status.count == '0)
    else $error("terminator did not reset decode state");

  // every terminator produces a result
  a_term_pushes: assert property (@(posedge clk) disable iff (rst)
    accept && in_byte == ced_pkg::CH_NUL |-> push.n != 2'd0)
    else $error("terminator produced no result");

endmodule

// ===== hw/rtl/ced_step.sv =====
// decode state registers and the per-byte decode logic
`timescale 1ns / 1ps

module ced_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                stop,
  input  logic [7:0]          kept,
  output ced_pkg::push_t      push,
  output ced_pkg::status_t    status
);

  ced_pkg::mode_t                  mode;
  ced_pkg::mode_t                  mode_next;
  logic [7:0]                      acc;
  logic [7:0]                      acc_next;
  logic [ced_pkg::COUNT_W-1:0]     count;
  logic [ced_pkg::COUNT_W-1:0]     count_next;

  logic [ced_pkg::COUNT_W-1:0]     count_inc;
  logic [4:0]                      hex;
  logic [7:0]                      acc_shift;

  ced_pkg::mode_t                  p_mode;
  logic [ced_pkg::COUNT_W-1:0]     p_count;
  logic                            p_v;
  ced_pkg::result_t                p_res;

  logic                            pre_v;
  ced_pkg::result_t                pre;
  logic                            m_v;
  ced_pkg::result_t                m;

  always_comb begin
    count_inc = (count == ced_pkg::COUNT_MAX) ? count : count + 1'b1;
    hex       = ced_pkg::hex_digit(in_byte);
    acc_shift = {acc[3:0], hex[3:0]};

    // handling of a byte outside any escape
    p_mode  = ced_pkg::MODE_NORMAL;
    p_count = count_inc;
    p_v     = 1'b0;
    p_res   = ced_pkg::mk_char(in_byte);
    priority if (in_byte == ced_pkg::CH_NUL) begin
      p_v     = 1'b1;
      p_res   = ced_pkg::mk_done(count_inc);
      p_count = '0;
    end else if (stop && (in_byte == ced_pkg::CH_QUOTE || in_byte < ced_pkg::CH_SPACE)) begin
      p_mode  = ced_pkg::MODE_STOPPED;
      p_count = count;
    end else if (in_byte == ced_pkg::CH_BSLASH) begin
      p_mode = ced_pkg::MODE_ESCAPE;
    end else begin
      p_v = !(in_byte < ced_pkg::CH_SPACE && in_byte != kept);
    end

    pre_v      = 1'b0;
    pre        = ced_pkg::mk_char(acc);
    m_v        = 1'b0;
    m          = p_res;
    mode_next  = ced_pkg::MODE_NORMAL;
    acc_next   = '0;
    count_next = count_inc;

    unique case (mode)
      ced_pkg::MODE_STOPPED: begin
        mode_next  = ced_pkg::MODE_STOPPED;
        count_next = count;
        if (in_byte == ced_pkg::CH_NUL) begin
          m_v        = 1'b1;
          m          = ced_pkg::mk_done(count);
          mode_next  = ced_pkg::MODE_NORMAL;
          count_next = '0;
        end
      end
      ced_pkg::MODE_ESCAPE: begin
        m_v = 1'b1;
        priority if (in_byte == ced_pkg::CH_NUL) begin
          m          = ced_pkg::mk_done(count_inc);
          count_next = '0;
        end else if (in_byte == ced_pkg::CH_T) begin
          m = ced_pkg::mk_char(ced_pkg::CH_TAB);
        end else if (in_byte == ced_pkg::CH_N) begin
          m = ced_pkg::mk_char(ced_pkg::CH_LF);
        end else if (in_byte == ced_pkg::CH_R) begin
          m = ced_pkg::mk_char(ced_pkg::CH_CR);
        end else if (in_byte == ced_pkg::CH_CR || in_byte == ced_pkg::CH_LF) begin
          // line continuation
          m_v = 1'b0;
        end else if (in_byte == ced_pkg::CH_X) begin
          m_v       = 1'b0;
          mode_next = ced_pkg::MODE_HEX0;
        end else begin
          m = ced_pkg::mk_char(in_byte);
        end
      end
      ced_pkg::MODE_HEX0, ced_pkg::MODE_HEX1: begin
        if (hex[4]) begin
          if (mode == ced_pkg::MODE_HEX0) begin
            mode_next = ced_pkg::MODE_HEX1;
            acc_next  = acc_shift;
          end else begin
            m_v = (acc_shift != ced_pkg::CH_NUL);
            m   = ced_pkg::mk_char(acc_shift);
          end
        end else begin
          // flush a one-digit escape, then treat the byte as plain
          pre_v      = (mode == ced_pkg::MODE_HEX1) && (acc != ced_pkg::CH_NUL);
          m_v        = p_v;
          mode_next  = p_mode;
          count_next = p_count;
        end
      end
      default: begin
        m_v        = p_v;
        mode_next  = p_mode;
        count_next = p_count;
      end
    endcase

    push.n = {1'b0, pre_v} + {1'b0, m_v};
    push.a = pre_v ? pre : m;
    push.a.last = !(pre_v && m_v);
    push.b = m;
    push.b.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= ced_pkg::MODE_NORMAL;
      acc   <= '0;
      count <= '0;
    end else if (accept) begin
      mode  <= mode_next;
      acc   <= acc_next;
      count <= count_next;
    end
  end

  assign status.mode  = mode;
  assign status.count = count;

endmodule

// ===== hw/rtl/ced_rq.sv =====
// result queue: takes up to two results per cycle, gives one per cycle while head_ready is high
`timescale 1ns / 1ps

module ced_rq (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  ced_pkg::push_t     push,
  output logic               space_ok,
  output logic               head_valid,
  input  logic               head_ready,
  output ced_pkg::result_t   head
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  ced_pkg::result_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      fill;
  logic [1:0]       n_in;
  logic             pop;

  assign n_in       = wr_en ? push.n : 2'd0;
  assign head_valid = (fill != '0);
  assign pop        = head_valid && head_ready;
  // room for the worst case of two results
  assign space_ok   = (fill <= (AW+1)'(DEPTH - 2));
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem[wr_ptr] <= push.a;
    end
    if (n_in == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(n_in);
      rd_ptr <= rd_ptr + AW'(pop);
      fill   <= fill + (AW+1)'(n_in) - (AW+1)'(pop);
    end
  end

endmodule

// ===== bench/c_escape_sequence_decoder_tb.sv =====
// self-checking testbench for the c escape sequence decoder
`timescale 1ns / 1ps

module c_escape_sequence_decoder_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic [14:0] consumed_count;
  logic        last_of_run;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = 8'h00;

  c_escape_sequence_decoder uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_byte(out_byte),
    .consumed_count(consumed_count),
    .last_of_run(last_of_run),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Verification failed");
    $finish;
  end

  // decoder mirror: string state and register copies
  ced_pkg::mode_t              dec_mode = ced_pkg::MODE_NORMAL;
  logic [7:0]                  hex_acc = 8'h00;
  logic [ced_pkg::COUNT_W-1:0] byte_cnt = '0;
  logic                        stop_on_quote = 1'b0;
  logic [7:0]                  kept_ctrl = 8'h00;

  ced_pkg::result_t step_results[$];
  ced_pkg::result_t pending_results[$];

  int  items_sent = 0;
  int  chars_seen = 0;
  int  strings_done = 0;
  int  mismatch_count = 0;
  int  settings_used = 0;
  bit  no_idle = 1'b0;
  int  ready_left = 0;

  function automatic logic [4:0] hex_lookup(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    return 5'd0;
  endfunction

  function automatic void bump_count();
    if (byte_cnt != ced_pkg::COUNT_MAX) byte_cnt = byte_cnt + 1'b1;
  endfunction

  function automatic void add_char(input logic [7:0] ch);
    ced_pkg::result_t r;
    if (ch != ced_pkg::CH_NUL) begin
      r = '0;
      r.kind = ced_pkg::KIND_CHAR;
      r.ch = ch;
      step_results.push_back(r);
    end
  endfunction

  function automatic void end_string();
    ced_pkg::result_t r;
    r = '0;
    r.kind = ced_pkg::KIND_DONE;
    r.count = byte_cnt;
    step_results.push_back(r);
    dec_mode = ced_pkg::MODE_NORMAL;
    hex_acc = 8'h00;
    byte_cnt = '0;
  endfunction

  function automatic void take_plain(input logic [7:0] c);
    if (c == ced_pkg::CH_NUL) begin
      bump_count();
      end_string();
    end else if (stop_on_quote && (c == ced_pkg::CH_QUOTE || c < ced_pkg::CH_SPACE)) begin
      // stopping byte is not counted
      dec_mode = ced_pkg::MODE_STOPPED;
    end else begin
      bump_count();
      if (c == ced_pkg::CH_BSLASH) begin
        dec_mode = ced_pkg::MODE_ESCAPE;
      end else if (!(c < ced_pkg::CH_SPACE && c != kept_ctrl)) begin
        add_char(c);
      end
    end
  endfunction

  // expected results of one accepted byte, appended to pending_results
  function automatic void decode_byte(input logic [7:0] c);
    logic [4:0]       dig;
    ced_pkg::result_t r;
    step_results = {};
    case (dec_mode)
      ced_pkg::MODE_STOPPED: begin
        if (c == ced_pkg::CH_NUL) end_string();
      end
      ced_pkg::MODE_ESCAPE: begin
        bump_count();
        dec_mode = ced_pkg::MODE_NORMAL;
        case (c)
          ced_pkg::CH_NUL: end_string();
          ced_pkg::CH_T: add_char(ced_pkg::CH_TAB);
          ced_pkg::CH_N: add_char(ced_pkg::CH_LF);
          ced_pkg::CH_R: add_char(ced_pkg::CH_CR);
          ced_pkg::CH_CR, ced_pkg::CH_LF: ;  // line continuation
          ced_pkg::CH_X: begin
            hex_acc = 8'h00;
            dec_mode = ced_pkg::MODE_HEX0;
          end
          default: add_char(c);
        endcase
      end
      ced_pkg::MODE_HEX0, ced_pkg::MODE_HEX1: begin
        dig = hex_lookup(c);
        if (dig[4]) begin
          bump_count();
          hex_acc = {hex_acc[3:0], dig[3:0]};
          if (dec_mode == ced_pkg::MODE_HEX0) begin
            dec_mode = ced_pkg::MODE_HEX1;
          end else begin
            dec_mode = ced_pkg::MODE_NORMAL;
            add_char(hex_acc);
            hex_acc = 8'h00;
          end
        end else begin
          // digits ended early: flush what was gathered, then the byte as usual
          if (dec_mode == ced_pkg::MODE_HEX1) add_char(hex_acc);
          hex_acc = 8'h00;
          dec_mode = ced_pkg::MODE_NORMAL;
          take_plain(c);
        end
      end
      default: begin
        dec_mode = ced_pkg::MODE_NORMAL;
        take_plain(c);
      end
    endcase
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endfunction

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    decode_byte(b);
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic stop_sending();
    if (in_valid) in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    // a byte that gives no result may still be in flight
    repeat (4) @(negedge clk);
  endtask

  // both registers in turn, write enable held across both writes
  task automatic set_config(input logic stop, input logic [7:0] kept);
    cfg_write <= 1'b1;
    cfg_index <= ced_pkg::REG_STOP;
    cfg_data <= {7'd0, stop};
    stop_on_quote = stop;
    @(negedge clk);
    cfg_index <= ced_pkg::REG_KEPT;
    cfg_data <= kept;
    kept_ctrl = kept;
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] hex_char();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'(8'h30 + k);
    if (k < 16) return 8'(8'h61 + k - 10);
    return 8'(8'h41 + k - 16);
  endfunction

  function automatic logic [7:0] simple_escape();
    case ($urandom_range(0, 4))
      0: return ced_pkg::CH_T;
      1: return ced_pkg::CH_N;
      2: return ced_pkg::CH_R;
      3: return ced_pkg::CH_CR;
      default: return ced_pkg::CH_LF;
    endcase
  endfunction

  task automatic send_random_string(input bit noisy);
    int len;
    int pick;
    int k;
    int nd;
    len = $urandom_range(0, 16);
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (noisy) begin
        send_byte(8'($urandom_range(1, 255)));
      end else if (pick < 40) begin
        send_byte(8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 50) begin
        send_byte(8'($urandom_range(8'h80, 8'hFF)));
      end else if (pick < 54) begin
        send_byte(kept_ctrl);
      end else if (pick < 58) begin
        send_byte(8'($urandom_range(1, 31)));
      end else if (pick < 62) begin
        send_byte(ced_pkg::CH_QUOTE);
      end else if (pick < 70) begin
        send_byte(ced_pkg::CH_BSLASH);
        send_byte(simple_escape());
      end else if (pick < 85) begin
        // zero to three digits: a third one is a plain byte again
        send_byte(ced_pkg::CH_BSLASH);
        send_byte(ced_pkg::CH_X);
        nd = $urandom_range(0, 3);
        repeat (nd) send_byte(hex_char());
      end else begin
        send_byte(ced_pkg::CH_BSLASH);
        send_byte(8'($urandom_range(1, 255)));
      end
    end
    if ($urandom_range(0, 9) == 0) send_byte(ced_pkg::CH_BSLASH);
    send_byte(ced_pkg::CH_NUL);
  endtask

  task automatic test_escapes();
    logic [7:0] seq [0:23];
    seq = '{8'h61, 8'hFF, 8'h01, ced_pkg::CH_BSLASH, ced_pkg::CH_T,
            ced_pkg::CH_BSLASH, ced_pkg::CH_N, ced_pkg::CH_BSLASH,
            ced_pkg::CH_R, ced_pkg::CH_BSLASH, ced_pkg::CH_LF,
            ced_pkg::CH_BSLASH, ced_pkg::CH_CR, ced_pkg::CH_BSLASH,
            ced_pkg::CH_X, 8'h41, 8'h66, ced_pkg::CH_BSLASH, ced_pkg::CH_X,
            8'h37, ced_pkg::CH_QUOTE, ced_pkg::CH_BSLASH, ced_pkg::CH_X, 8'h71};
    foreach (seq[i]) send_byte(seq[i]);
    // backslash before the terminator
    send_byte(ced_pkg::CH_BSLASH);
    send_byte(ced_pkg::CH_NUL);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_stop_and_kept();
    set_config(1'b0, 8'hFF);
    send_byte(8'h7A);
    stop_sending();
    wait_drained();
    // stop mode switched on in the middle of a string
    set_config(1'b1, 8'hFF);
    send_byte(8'h79);
    send_byte(ced_pkg::CH_QUOTE);
    send_byte(8'h77);
    send_byte(ced_pkg::CH_NUL);
    stop_sending();
    wait_drained();
    set_config(1'b0, 8'h1F);
    send_byte(8'h1F);
    send_byte(8'h1E);
    send_byte(ced_pkg::CH_NUL);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_count_saturation();
    set_config(1'b0, 8'h00);
    no_idle = 1'b1;
    // dropped control bytes are counted but give no result
    repeat (32770) send_byte(8'h02);
    send_byte(ced_pkg::CH_NUL);
    no_idle = 1'b0;
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int ph;
    int target;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(1'b0, 8'h00);
        1: set_config(1'b1, 8'hFF);
        2: set_config(1'b0, 8'($urandom_range(1, 31)));
        3: set_config(1'b1, 8'($urandom_range(0, 255)));
        4: set_config(1'b0, 8'hFF);
        default: set_config(1'($urandom_range(0, 1)), 8'($urandom_range(1, 31)));
      endcase
      no_idle = (ph == 2);
      target = items_sent + 135;
      while (items_sent < target) send_random_string($urandom_range(0, 9) == 0);
      no_idle = 1'b0;
      stop_sending();
      wait_drained();
    end
  endtask

  always @(negedge clk) begin : ready_gen
    int roll;
    if (no_idle) begin
      out_ready <= 1'b1;
      ready_left = 0;
    end else if (ready_left > 0) begin
      ready_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        out_ready <= 1'b1;
        ready_left = $urandom_range(0, 7);
      end else if (roll < 92) begin
        out_ready <= 1'b0;
        ready_left = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b0;
        ready_left = $urandom_range(9, 29);
      end
    end
  end

  always @(posedge clk) begin : result_check
    ced_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: kind %0d byte %h count %0d",
               out_kind, out_byte, consumed_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_kind != want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
          mismatch_count++;
        end
        if (out_byte != want.ch) begin
          $error("out_byte: expected %h, got %h", want.ch, out_byte);
          mismatch_count++;
        end
        if (consumed_count != want.count) begin
          $error("consumed_count: expected %0d, got %0d", want.count, consumed_count);
          mismatch_count++;
        end
        if (last_of_run != want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
          mismatch_count++;
        end
        if (want.kind == ced_pkg::KIND_DONE) strings_done++;
        else chars_seen++;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_escapes();
    test_stop_and_kept();
    test_count_saturation();
    test_random_traffic();
    stop_sending();
    wait_drained();
    repeat (10) @(negedge clk);
    $display("decoded %0d bytes into %0d characters and %0d string ends",
             items_sent, chars_seen, strings_done);
    $display("%0d register settings, %0d field mismatches", settings_used,
             mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== c_escape_sequence_decoder.f =====
hw/rtl/ced_pkg.sv
hw/rtl/ced_step.sv
hw/rtl/ced_rq.sv
hw/rtl/c_escape_sequence_decoder.sv
bench/c_escape_sequence_decoder_tb.sv
